@@ design/nsr_pkg.sv @@
// package with shared constants and types for the newton square root block
`timescale 1ns / 1ps
package nsr_pkg;
	localparam int DATA_WIDTH = 32;
	localparam int FRACTION_BITS = 16;
	localparam int RADICAND_WIDTH = 32;
	localparam int ROOT_WIDTH = 32;
	localparam int TOL_WIDTH = 16;
	localparam int LIMIT_WIDTH = 6;
	localparam int CFG_INDEX_WIDTH = 1;
	localparam int CFG_DATA_WIDTH = 16;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 1'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_ITERATION_LIMIT = 1'd1;
	localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd7;
	localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 6'd32;

	typedef struct packed {
		logic [RADICAND_WIDTH-1:0] radicand;
	} in_item_t;

	typedef struct packed {
		logic [ROOT_WIDTH-1:0] root;
		logic negative_input;
		logic converged;
	} out_item_t;
endpackage

@@ design/nsr_if.sv @@
// valid/ready channel interface
`timescale 1ns / 1ps
interface nsr_in_if;
	logic valid;
	logic ready;
	nsr_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nsr_out_if;
	logic valid;
	logic ready;
	nsr_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/newton_square_root.sv @@
// newton square root: iterative fixed-point root with one shared serial divider
// each step runs the check state, then the bit-serial restoring divider (one quotient
// bit per cycle), then the update state; a negative input goes straight to the done
// state without any step
// one item at a time; the input is not ready while an item is in work or waiting
// arst_n clears control state and sets tolerance to 7 and the limit to 32
`timescale 1ns / 1ps
module newton_square_root #(
	parameter int DATA_WIDTH = nsr_pkg::DATA_WIDTH,
	parameter int FRACTION_BITS = nsr_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [nsr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input logic [nsr_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
	nsr_in_if.sink in_ch,
	nsr_out_if.source out_ch
);
	localparam int NW = nsr_pkg::RADICAND_WIDTH;
	localparam int DIVW = NW - 1 + FRACTION_BITS;
	localparam int SQW = 2 * DATA_WIDTH;
	localparam int CW = $clog2(DIVW + 1);
	localparam int RW = DATA_WIDTH + 1;
	localparam int SUMW = (DIVW > DATA_WIDTH) ? DIVW : DATA_WIDTH;

	typedef enum logic [2:0] {S_IDLE, S_CHECK, S_DIV, S_UPDATE, S_DONE} state_t;

	state_t state_q;
	logic [nsr_pkg::TOL_WIDTH-1:0] tol_q;
	logic [nsr_pkg::LIMIT_WIDTH-1:0] limit_q, steps_q;
	logic [NW-2:0] n_q;
	logic [DATA_WIDTH-1:0] g_q;
	logic [DIVW-1:0] dvd_q;
	logic [DIVW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [CW-1:0] cnt_q;
	nsr_pkg::out_item_t res_q;

	logic [SQW-1:0] sq_full;
	logic [SQW-1:0] sq_sh;
	logic [SQW:0] err;
	logic conv;
	logic [RW:0] rem_sh;
	logic [RW:0] rem_sub;
	logic [SUMW:0] sum;
	logic [SUMW-1:0] g_wide;
	logic [SUMW-1:0] gmax_wide;
	logic [DATA_WIDTH-1:0] g_new;

	always_comb begin
		sq_full = g_q * g_q;
		sq_sh = sq_full >> FRACTION_BITS;
		if (sq_sh >= SQW'(n_q))
			err = {1'b0, sq_sh - SQW'(n_q)};
		else
			err = {1'b0, SQW'(n_q) - sq_sh};
		conv = err < (SQW + 1)'(tol_q);
		rem_sh = {rem_q, dvd_q[DIVW-1]};
		rem_sub = rem_sh - (RW + 1)'(g_q);
		g_wide = SUMW'(g_q);
		sum = {1'b0, SUMW'(quo_q)} + {1'b0, g_wide};
		gmax_wide = SUMW'({DATA_WIDTH{1'b1}});
		if (sum[SUMW:1] > gmax_wide)
			g_new = {DATA_WIDTH{1'b1}};
		else
			g_new = sum[DATA_WIDTH:1];
	end

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_DONE);
	assign out_ch.data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q <= nsr_pkg::TOL_RESET;
			limit_q <= nsr_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nsr_pkg::REG_TOLERANCE: tol_q <= cfg_data[nsr_pkg::TOL_WIDTH-1:0];
					nsr_pkg::REG_ITERATION_LIMIT:
						limit_q <= cfg_data[nsr_pkg::LIMIT_WIDTH-1:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						n_q <= in_ch.data.radicand[NW-2:0];
						steps_q <= '0;
						if (DATA_WIDTH > FRACTION_BITS)
							g_q <= DATA_WIDTH'(1) << FRACTION_BITS;
						else
							g_q <= {DATA_WIDTH{1'b1}};
						if (in_ch.data.radicand[NW-1]) begin
							res_q.root <= nsr_pkg::ROOT_WIDTH'(1) << 16;
							res_q.negative_input <= 1'b1;
							res_q.converged <= 1'b0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					if (conv || steps_q >= limit_q) begin
						res_q.root <= (DATA_WIDTH > nsr_pkg::ROOT_WIDTH &&
							(g_q >> nsr_pkg::ROOT_WIDTH) != '0) ?
							{nsr_pkg::ROOT_WIDTH{1'b1}} : nsr_pkg::ROOT_WIDTH'(g_q);
						res_q.negative_input <= 1'b0;
						res_q.converged <= conv;
						state_q <= S_DONE;
					end else begin
						steps_q <= steps_q + 1'b1;
						dvd_q <= {n_q, {FRACTION_BITS{1'b0}}};
						quo_q <= '0;
						rem_q <= '0;
						cnt_q <= CW'(DIVW);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					dvd_q <= dvd_q << 1;
					if (!rem_sub[RW]) begin
						rem_q <= rem_sub[RW-1:0];
						quo_q <= {quo_q[DIVW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[RW-1:0];
						quo_q <= {quo_q[DIVW-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CW'(1))
						state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					g_q <= g_new;
					if (g_new == '0) begin
						res_q.root <= '0;
						res_q.negative_input <= 1'b0;
						res_q.converged <= 1'b0;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_DONE: begin
					if (out_ch.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
